/* sv/lcss_pkg.sv */
// ----------------------------------------------------------------------------
// Load cell sample smoother package
// Shared constants, codes and types for the trimmed moving average block.
// ----------------------------------------------------------------------------
package lcss_pkg;

  localparam int WINDOW_MAX   = 16;
  localparam int TRIM_HIGH    = 1;
  localparam int TRIM_LOW     = 1;
  localparam int TARE_SAMPLES = 18;

  localparam int RING_DEPTH   = WINDOW_MAX + TRIM_HIGH + TRIM_LOW;
  localparam int DATA_W       = 24;
  localparam int NET_W        = DATA_W + 1;
  localparam int IDX_W        = $clog2(RING_DEPTH);
  localparam int LEN_W        = $clog2(RING_DEPTH + 1);
  localparam int SUM_W        = DATA_W + $clog2(RING_DEPTH + 1);
  localparam int PROG_W       = $clog2(TARE_SAMPLES + 1);
  localparam int K_W          = 3;
  localparam int WIN_LOG2_MAX = $clog2(WINDOW_MAX + 1) - 1;

  localparam logic [DATA_W-1:0] MASK24    = 24'hFFFFFF;
  localparam logic [DATA_W-1:0] SIGN_FLIP = 24'h800000;

  // request kinds carried in the input tuser
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_TARE   = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;

  // result status carried in the output tuser
  localparam logic [1:0] STAT_NONE   = 2'd0;
  localparam logic [1:0] STAT_STORED = 2'd1;
  localparam logic [1:0] STAT_TARE   = 2'd2;

  // configuration register indexes
  localparam logic REG_WINDOW_LOG2 = 1'b0;
  localparam logic REG_REVERSE     = 1'b1;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_TRIM
  } acc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_TRIM,
    ST_DONE
  } seq_state_e;

endpackage

/* sv/lcss_ring.sv */
// ----------------------------------------------------------------------------
// Sample ring
// Register ring of offset-binary samples, one write and one read port.
// ----------------------------------------------------------------------------
module lcss_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [lcss_pkg::IDX_W-1:0]    wr_addr_i,
  input  logic [lcss_pkg::DATA_W-1:0]   wr_data_i,
  input  logic [lcss_pkg::IDX_W-1:0]    rd_addr_i,
  output logic [lcss_pkg::DATA_W-1:0]   rd_data_o
);

  logic [lcss_pkg::DATA_W-1:0] ring_q [lcss_pkg::RING_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lcss_pkg::RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (we_i) begin
      ring_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = ring_q[rd_addr_i];

endmodule

/* sv/lcss_accum.sv */
// ----------------------------------------------------------------------------
// Shared accumulate unit
// Running sum, minimum and maximum over the ring walk, then trim.
// ----------------------------------------------------------------------------
module lcss_accum (
  input  logic                          clk_i,
  input  lcss_pkg::acc_op_e             op_i,
  input  logic [lcss_pkg::DATA_W-1:0]   sample_i,
  output logic [lcss_pkg::SUM_W-1:0]    sum_o
);

  logic [lcss_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [lcss_pkg::DATA_W-1:0] lo_q, lo_d;
  logic [lcss_pkg::DATA_W-1:0] hi_q, hi_d;
  logic [lcss_pkg::SUM_W-1:0]  lo_trim, hi_trim;

  assign lo_trim = (lcss_pkg::TRIM_LOW != 0)  ? lcss_pkg::SUM_W'(lo_q) : '0;
  assign hi_trim = (lcss_pkg::TRIM_HIGH != 0) ? lcss_pkg::SUM_W'(hi_q) : '0;

  always_comb begin
    sum_d = sum_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    case (op_i)
      lcss_pkg::ACC_CLEAR: begin
        sum_d = '0;
        lo_d  = lcss_pkg::MASK24;
        hi_d  = '0;
      end
      lcss_pkg::ACC_ADD: begin
        sum_d = sum_q + lcss_pkg::SUM_W'(sample_i);
        if (sample_i < lo_q) lo_d = sample_i;
        if (sample_i > hi_q) hi_d = sample_i;
      end
      lcss_pkg::ACC_TRIM: begin
        sum_d = sum_q - lo_trim - hi_trim;
      end
      default: begin
        sum_d = sum_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
  end

  assign sum_o = sum_q;

endmodule

/* sv/load_cell_sample_smoother_top.sv */
// ----------------------------------------------------------------------------
// Load cell sample smoother
// Trimmed moving average of bridge converter words with tare capture.
// ----------------------------------------------------------------------------
// Input stream: tuser holds the request kind (sample, start tare, load
// offset), tdata holds the conversion word and the offset to load.
// Output stream: one transfer per accepted input, tdata holds the smoothed
// value and the signed net value, tuser holds the status.
// Each result is formed over a walk of len ring entries, where
// len = 2^k + 2 ring entries (18 entries at k = 4):
// the shared accumulate unit walks one ring entry per cycle, then the trim
// step subtracts min and max, and the final step shifts, saturates, forms the net
// value and loads the output register.
// s_axis_tready_o is high only while the sequencer idles, so a new item
// is taken only once the previous item has left the final step.
// A finished result sits in the output register; the next item is taken and
// walked while it waits, and only the final step holds until the receiver
// takes the pending result.
// Reset clears the ring, the write position, tare state and offset, sets the
// window to 16 samples and leaves the output empty.
// Configuration writes take effect at once and belong between items.
// ----------------------------------------------------------------------------
module load_cell_sample_smoother_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // raw_sample [23:0], tare_value [47:24]
  input  logic [1:0]  s_axis_tuser_i,   // req_type [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // smoothed [23:0], net_value [48:24]
  output logic [1:0]  m_axis_tuser_o    // status [1:0]
);

  localparam int DW = lcss_pkg::DATA_W;

  lcss_pkg::seq_state_e state_q, state_d;
  lcss_pkg::acc_op_e    acc_op;

  logic [lcss_pkg::K_W-1:0]    win_log2_q, k_eff, k_q;
  logic                        reverse_q;
  logic [lcss_pkg::IDX_W-1:0]  wp_q, wp_d;
  logic [lcss_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [lcss_pkg::LEN_W-1:0]  len, len_q;
  logic [lcss_pkg::LEN_W:0]    wp_inc;
  logic                        pend_q, pend_d;
  logic [lcss_pkg::PROG_W-1:0] prog_q, prog_d;
  logic [DW-1:0]               offset_q, offset_d;
  logic                        cap_q, cap_d;
  logic [1:0]                  stat_q, stat_d;

  logic                        in_xfer, out_free;
  logic [DW-1:0]               data_flip, data_in;
  logic                        ring_we;
  logic [DW-1:0]               ring_rdata;
  logic [lcss_pkg::SUM_W-1:0]  sum, sum_sh;
  logic [DW-1:0]               sm;
  logic [lcss_pkg::NET_W-1:0]  net;

  logic                        out_valid_q;
  logic [DW-1:0]               sm_q;
  logic [lcss_pkg::NET_W-1:0]  net_q;
  logic [1:0]                  out_stat_q;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Saturate the window to the ring size
  assign k_eff = (win_log2_q > lcss_pkg::K_W'(lcss_pkg::WIN_LOG2_MAX))
               ? lcss_pkg::K_W'(lcss_pkg::WIN_LOG2_MAX) : win_log2_q;
  assign len   = (lcss_pkg::LEN_W'(1) << k_eff)
               + lcss_pkg::LEN_W'(lcss_pkg::TRIM_HIGH + lcss_pkg::TRIM_LOW);
  assign wp_inc = (lcss_pkg::LEN_W+1)'(wp_q) + (lcss_pkg::LEN_W+1)'(1);

  assign data_flip = s_axis_tdata_i[DW-1:0] ^ lcss_pkg::SIGN_FLIP;
  assign data_in   = reverse_q ? (lcss_pkg::MASK24 - data_flip) : data_flip;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_log2_q <= lcss_pkg::K_W'(4);
      reverse_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcss_pkg::REG_WINDOW_LOG2: win_log2_q <= cfg_wdata_i;
        lcss_pkg::REG_REVERSE:     reverse_q  <= cfg_wdata_i[0];
        default:                   reverse_q  <= reverse_q;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    acc_op    = lcss_pkg::ACC_HOLD;
    wp_d      = wp_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    prog_d    = prog_q;
    offset_d  = offset_q;
    cap_d     = cap_q;
    stat_d    = stat_q;
    ring_we   = 1'b0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      lcss_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          acc_op  = lcss_pkg::ACC_CLEAR;
          idx_d   = '0;
          cap_d   = 1'b0;
          stat_d  = lcss_pkg::STAT_NONE;
          state_d = lcss_pkg::ST_WALK;
          case (s_axis_tuser_i)
            lcss_pkg::REQ_SAMPLE: begin
              wp_d = (wp_inc >= (lcss_pkg::LEN_W+1)'(len))
                   ? '0 : lcss_pkg::IDX_W'(wp_inc);
              if (data_in != '0) begin
                ring_we = 1'b1;
                stat_d  = lcss_pkg::STAT_STORED;
                if (pend_q) begin
                  if (prog_q < lcss_pkg::PROG_W'(lcss_pkg::TARE_SAMPLES)) begin
                    prog_d = prog_q + lcss_pkg::PROG_W'(1);
                  end else begin
                    prog_d = '0;
                    pend_d = 1'b0;
                    cap_d  = 1'b1;
                    stat_d = lcss_pkg::STAT_TARE;
                  end
                end
              end
            end
            lcss_pkg::REQ_TARE: begin
              pend_d = 1'b1;
              prog_d = '0;
            end
            lcss_pkg::REQ_LOAD: begin
              offset_d = s_axis_tdata_i[2*DW-1:DW];
            end
            default: begin
              stat_d = lcss_pkg::STAT_NONE;
            end
          endcase
        end
      end
      lcss_pkg::ST_WALK: begin
        acc_op = lcss_pkg::ACC_ADD;
        if ((lcss_pkg::LEN_W)'(idx_q) == len_q - lcss_pkg::LEN_W'(1)) begin
          state_d = lcss_pkg::ST_TRIM;
        end else begin
          idx_d = idx_q + lcss_pkg::IDX_W'(1);
        end
      end
      lcss_pkg::ST_TRIM: begin
        acc_op  = lcss_pkg::ACC_TRIM;
        state_d = lcss_pkg::ST_DONE;
      end
      lcss_pkg::ST_DONE: begin
        if (out_free) begin
          if (cap_q) offset_d = sm;
          state_d = lcss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lcss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lcss_pkg::ST_IDLE;
      wp_q     <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      prog_q   <= '0;
      offset_q <= '0;
      cap_q    <= 1'b0;
      stat_q   <= lcss_pkg::STAT_NONE;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      prog_q   <= prog_d;
      offset_q <= offset_d;
      cap_q    <= cap_d;
      stat_q   <= stat_d;
    end
  end

  // Latch the walk length and shift for this item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      len_q <= len;
      k_q   <= k_eff;
    end
  end

  lcss_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (ring_we),
    .wr_addr_i (wp_d),
    .wr_data_i (data_in),
    .rd_addr_i (idx_q),
    .rd_data_o (ring_rdata)
  );

  lcss_accum u_accum (
    .clk_i    (clk_i),
    .op_i     (acc_op),
    .sample_i (ring_rdata),
    .sum_o    (sum)
  );

  // Shift, saturate and subtract the offset in effect after this item
  assign sum_sh = sum >> k_q;
  assign sm     = (sum_sh > lcss_pkg::SUM_W'(lcss_pkg::MASK24))
                ? lcss_pkg::MASK24 : sum_sh[DW-1:0];
  assign net    = {1'b0, sm} - {1'b0, offset_d};

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == lcss_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lcss_pkg::ST_DONE && out_free) begin
      sm_q       <= sm;
      net_q      <= net;
      out_stat_q <= stat_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, net_q, sm_q};
  assign m_axis_tuser_o  = out_stat_q;

  // The walk index stays inside the latched ring length
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lcss_pkg::ST_WALK |-> lcss_pkg::LEN_W'(idx_q) < len_q)
    else $error("walk index beyond ring length");

  // The write position never leaves the ring
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcss_pkg::LEN_W'(wp_q) < lcss_pkg::LEN_W'(lcss_pkg::RING_DEPTH))
    else $error("write position beyond ring");

  // A captured tare makes the reported net value zero
  a_tare_net: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == lcss_pkg::STAT_TARE
      |-> m_axis_tdata_o[48:24] == '0)
    else $error("net value not zero on tare capture");

  // A result appears only after the final step of an item
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == lcss_pkg::ST_DONE)
    else $error("result without finished item");

endmodule
